// File: sv/rsc_pkg.sv
// constants shared by the spherical-to-cartesian datapath
// arctangent table, cordic gain and fixed-point widths; no dependencies
package rsc_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned TURN_W       = 32;
  localparam int unsigned ZW           = TURN_W + 1;
  localparam int unsigned ATAN_ENTRIES = 24;

  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// File: sv/rsc_cordic_cell.sv
// one registered cordic micro-rotation with a fixed shift and arctangent
// depends on rsc_pkg
module rsc_cordic_cell #(
  parameter int unsigned W    = 34,
  parameter int unsigned SB_W = 8,
  parameter int unsigned IDX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [rsc_pkg::ZW-1:0] z_i,
  input  logic [SB_W-1:0]               sb_i,
  output logic                          valid_o,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [rsc_pkg::ZW-1:0] z_o,
  output logic [SB_W-1:0]               sb_o
);
  import rsc_pkg::*;

  logic signed [W-1:0]  dx, dy, x_d, y_d;
  logic signed [ZW-1:0] atan, z_d;
  logic                 valid_q;
  logic signed [W-1:0]  x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [SB_W-1:0]      sb_q;

  assign atan = $signed({1'b0, ATAN_TURN[IDX]});
  assign dx   = y_i >>> IDX;
  assign dy   = x_i >>> IDX;

  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      sb_q <= sb_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign sb_o    = sb_q;

endmodule

// File: sv/rsc_cordic.sv
// rotation unit: quadrant fold stage followed by a row of cordic cells
// depends on rsc_pkg and rsc_cordic_cell
module rsc_cordic #(
  parameter int unsigned W             = 34,
  parameter int unsigned SB_W          = 8,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [W-1:0]               x_i,
  input  logic signed [W-1:0]               y_i,
  input  logic [rsc_pkg::TURN_W-1:0]        ang_i,
  input  logic [SB_W-1:0]                   sb_i,
  output logic                              valid_o,
  output logic signed [W-1:0]               x_o,
  output logic signed [W-1:0]               y_o,
  output logic [SB_W-1:0]                   sb_o
);
  import rsc_pkg::*;

  logic                 flip;
  logic                 v0_q;
  logic signed [W-1:0]  x0_q, y0_q;
  logic signed [ZW-1:0] z0_q;
  logic [SB_W-1:0]      sb0_q;
  logic                 v_c  [CORDIC_STAGES+1];
  logic signed [W-1:0]  x_c  [CORDIC_STAGES+1];
  logic signed [W-1:0]  y_c  [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_c  [CORDIC_STAGES+1];
  logic [SB_W-1:0]      sb_c [CORDIC_STAGES+1];

  // second and third quadrant: negate the vector and turn by half a turn
  assign flip = ang_i[TURN_W-1] ^ ang_i[TURN_W-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q  <= flip ? -x_i : x_i;
      y0_q  <= flip ? -y_i : y_i;
      z0_q  <= $signed({ang_i[TURN_W-1] ^ flip, ang_i[TURN_W-1] ^ flip,
                        ang_i[TURN_W-2:0]});
      sb0_q <= sb_i;
    end
  end

  assign v_c[0]  = v0_q;
  assign x_c[0]  = x0_q;
  assign y_c[0]  = y0_q;
  assign z_c[0]  = z0_q;
  assign sb_c[0] = sb0_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rsc_cordic_cell #(
      .W    (W),
      .SB_W (SB_W),
      .IDX  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v_c[i]),
      .x_i     (x_c[i]),
      .y_i     (y_c[i]),
      .z_i     (z_c[i]),
      .sb_i    (sb_c[i]),
      .valid_o (v_c[i+1]),
      .x_o     (x_c[i+1]),
      .y_o     (y_c[i+1]),
      .z_o     (z_c[i+1]),
      .sb_o    (sb_c[i+1])
    );
  end

  assign valid_o = v_c[CORDIC_STAGES];
  assign x_o     = x_c[CORDIC_STAGES];
  assign y_o     = y_c[CORDIC_STAGES];
  assign sb_o    = sb_c[CORDIC_STAGES];

endmodule

// File: sv/rsc_gain.sv
// cordic gain compensation: sign-magnitude multiply by 1/K in 32-bit halves
// depends on rsc_pkg
module rsc_gain #(
  parameter int unsigned W    = 34,
  parameter int unsigned SB_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] v_i,
  input  logic [SB_W-1:0]     sb_i,
  output logic                valid_o,
  output logic signed [W-1:0] v_o,
  output logic [SB_W-1:0]     sb_o
);
  import rsc_pkg::*;

  localparam int unsigned MW   = (W > 33) ? W : 33;
  localparam int unsigned HI_W = MW - 32;

  logic [W-1:0]    mag;
  logic [MW-1:0]   prod_hi;
  logic [63:0]     prod_lo;

  logic [3:0]      v_q;
  logic [SB_W-1:0] sb1_q, sb2_q, sb3_q, sb4_q;
  logic            neg1_q, neg2_q, neg3_q;
  logic [MW-1:0]   m1_q;
  logic [HI_W-1:0] hi2_q;
  logic [31:0]     plo2_q;
  logic [MW-1:0]   p3_q;
  logic signed [W-1:0] r4_q;

  assign mag     = v_i[W-1] ? W'(-v_i) : W'(v_i);
  assign prod_lo = 64'(m1_q[31:0]) * 64'(INV_GAIN_Q32);
  assign prod_hi = MW'(hi2_q) * MW'(INV_GAIN_Q32) + MW'(plo2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= v_i[W-1];
      m1_q   <= MW'(mag);
      sb1_q  <= sb_i;

      neg2_q <= neg1_q;
      hi2_q  <= m1_q[MW-1:32];
      plo2_q <= prod_lo[63:32];
      sb2_q  <= sb1_q;

      neg3_q <= neg2_q;
      p3_q   <= prod_hi;
      sb3_q  <= sb2_q;

      r4_q   <= neg3_q ? -$signed(p3_q[W-1:0]) : $signed(p3_q[W-1:0]);
      sb4_q  <= sb3_q;
    end
  end

  assign valid_o = v_q[3];
  assign v_o     = r4_q;
  assign sb_o    = sb4_q;

endmodule

// File: sv/radar_spherical_to_cartesian.sv
// top level of the radar spherical-to-cartesian converter
// depends on rsc_pkg, rsc_cordic, rsc_gain
//
// Converts one radar return (range, azimuth, elevation) per clock into x, y, z
// in range units; amplitude and the scan end mark pass through. The datapath
// is a fully pipelined chain: a range scaling multiply, one cordic rotation by
// elevation (fold stage plus CORDIC_STAGES cells), a four-stage gain multiply,
// a second rotation by azimuth, a rounding stage and the output register.
// A new return is accepted every cycle; when the output side stalls, a skid
// register catches the item in flight and the whole chain holds until the
// result is taken.
module radar_spherical_to_cartesian #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned RANGE_BITS    = 16,
  parameter int unsigned ANGLE_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  // range_m, azimuth, elevation, amplitude
  input  logic [((RANGE_BITS+2*ANGLE_BITS+16+7)/8)*8-1:0] s_tdata_i,
  input  logic s_tlast_i,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  // pos_x, pos_y, pos_z, intensity
  output logic [((3*(RANGE_BITS+1)+16+7)/8)*8-1:0] m_tdata_o,
  output logic m_tlast_o
);
  import rsc_pkg::*;

  localparam int unsigned W       = RANGE_BITS + FRAC_BITS + 2;
  localparam int unsigned PW      = RANGE_BITS + 1;
  localparam int unsigned QW      = W - FRAC_BITS;
  localparam int unsigned OUT_W   = 3 * PW + 16;
  localparam int unsigned OUT_TDW = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned AZ_LO   = RANGE_BITS;
  localparam int unsigned EL_LO   = RANGE_BITS + ANGLE_BITS;
  localparam int unsigned AMP_LO  = RANGE_BITS + 2 * ANGLE_BITS;

  typedef struct packed {
    logic [RANGE_BITS-1:0] r;
    logic [TURN_W-1:0]     az;
    logic [15:0]           amp;
    logic                  last;
  } sb1_t;

  typedef struct packed {
    logic signed [W-1:0] zc;
    sb1_t                sb;
  } sbg_t;

  typedef struct packed {
    logic signed [W-1:0]   zc;
    logic [RANGE_BITS-1:0] r;
    logic [15:0]           amp;
    logic                  last;
  } sb2_t;

  logic en;
  logic [RANGE_BITS+31:0] scaled;

  logic                  v1_q;
  logic signed [W-1:0]   h1_q;
  logic [TURN_W-1:0]     el1_q;
  sb1_t                  sb1_q;

  logic                  ve_v;
  logic signed [W-1:0]   ve_x, ve_y;
  logic [$bits(sb1_t)-1:0] ve_sb;
  sbg_t                  gain_sb_in, gain_sb_out;
  logic                  vg_v;
  logic signed [W-1:0]   vg_x;
  logic [$bits(sbg_t)-1:0] vg_sb;
  sb2_t                  az_sb_in, az_sb_out;
  logic                  va_v;
  logic signed [W-1:0]   va_x, va_y;
  logic [$bits(sb2_t)-1:0] va_sb;

  logic                  vr_q;
  logic signed [QW-1:0]  rx_q, ry_q, rz_q;
  logic [RANGE_BITS-1:0] rr_q;
  logic [15:0]           ramp_q;
  logic                  rlast_q;

  logic signed [QW-1:0]  lim_p, lim_n, cx, cy, cz;
  logic [OUT_W:0]        pipe_data;
  logic                  pipe_v;

  logic                  out_v_q, skid_v_q;
  logic [OUT_W:0]        out_q, skid_q;

  function automatic logic signed [QW-1:0] clamp(logic signed [QW-1:0] v,
                                                 logic signed [QW-1:0] hi,
                                                 logic signed [QW-1:0] lo);
    logic signed [QW-1:0] res;
    res = v;
    if (v > hi) res = hi;
    if (v < lo) res = lo;
    return res;
  endfunction

  function automatic logic signed [QW-1:0] round_q(logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = v + W'(1 << (FRAC_BITS - 1));
    return t[W-1:FRAC_BITS];
  endfunction

  assign en         = !skid_v_q;
  assign s_tready_o = en;

  assign scaled = (RANGE_BITS+32)'(s_tdata_i[RANGE_BITS-1:0]) *
                  (RANGE_BITS+32)'(INV_GAIN_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_q      <= $signed({2'b00, scaled[RANGE_BITS+31:FRAC_BITS]});
      el1_q     <= {s_tdata_i[EL_LO+ANGLE_BITS-1:EL_LO], {(TURN_W-ANGLE_BITS){1'b0}}};
      sb1_q.r   <= s_tdata_i[RANGE_BITS-1:0];
      sb1_q.az  <= {s_tdata_i[AZ_LO+ANGLE_BITS-1:AZ_LO], {(TURN_W-ANGLE_BITS){1'b0}}};
      sb1_q.amp <= s_tdata_i[AMP_LO+15:AMP_LO];
      sb1_q.last <= s_tlast_i;
    end
  end

  rsc_cordic #(
    .W             (W),
    .SB_W          ($bits(sb1_t)),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_rot_el (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .x_i     (h1_q),
    .y_i     ('0),
    .ang_i   (el1_q),
    .sb_i    (sb1_q),
    .valid_o (ve_v),
    .x_o     (ve_x),
    .y_o     (ve_y),
    .sb_o    (ve_sb)
  );

  assign gain_sb_in.zc = ve_y;
  assign gain_sb_in.sb = sb1_t'(ve_sb);

  rsc_gain #(
    .W    (W),
    .SB_W ($bits(sbg_t))
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ve_v),
    .v_i     (ve_x),
    .sb_i    (gain_sb_in),
    .valid_o (vg_v),
    .v_o     (vg_x),
    .sb_o    (vg_sb)
  );

  assign gain_sb_out   = sbg_t'(vg_sb);
  assign az_sb_in.zc   = gain_sb_out.zc;
  assign az_sb_in.r    = gain_sb_out.sb.r;
  assign az_sb_in.amp  = gain_sb_out.sb.amp;
  assign az_sb_in.last = gain_sb_out.sb.last;

  rsc_cordic #(
    .W             (W),
    .SB_W          ($bits(sb2_t)),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_rot_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg_v),
    .x_i     (vg_x),
    .y_i     ('0),
    .ang_i   (gain_sb_out.sb.az),
    .sb_i    (az_sb_in),
    .valid_o (va_v),
    .x_o     (va_x),
    .y_o     (va_y),
    .sb_o    (va_sb)
  );

  assign az_sb_out = sb2_t'(va_sb);

  // round to nearest, halves up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en) begin
      vr_q <= va_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q    <= round_q(va_y);
      ry_q    <= round_q(va_x);
      rz_q    <= round_q(az_sb_out.zc);
      rr_q    <= az_sb_out.r;
      ramp_q  <= az_sb_out.amp;
      rlast_q <= az_sb_out.last;
    end
  end

  // clamp to [-r, r] against rounding overshoot
  assign lim_p = $signed({2'b00, rr_q});
  assign lim_n = -lim_p;
  assign cx    = clamp(rx_q, lim_p, lim_n);
  assign cy    = clamp(ry_q, lim_p, lim_n);
  assign cz    = clamp(rz_q, lim_p, lim_n);

  assign pipe_data = {rlast_q, ramp_q, cz[PW-1:0], cy[PW-1:0], cx[PW-1:0]};
  assign pipe_v    = vr_q && en;

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_tready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= pipe_v;
      end
    end else if (pipe_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_tready_i) begin
      out_q <= skid_v_q ? skid_q : pipe_data;
    end else if (pipe_v) begin
      skid_q <= pipe_data;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = OUT_TDW'(out_q[OUT_W-1:0]);
  assign m_tlast_o  = out_q[OUT_W];

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_tready_i))
    else $error("skid register filled without an output stall");

  a_skid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_tready_i |=> skid_v_q)
    else $error("skid register drained without a transfer");

endmodule
